>>> rtl/eqaa_pkg.sv
// Shared constants, types and the arctangent table for the alt-az converter.
package eqaa_pkg;

   // Field formats
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_STAGES   = 24;
   localparam int INT_FRAC        = 28;
   localparam int UP_SH           = INT_FRAC - ANGLE_FRAC_BITS;
   localparam int LAT_W           = 24;
   localparam int HA_W            = 21;
   localparam int DEC_W           = 24;
   localparam int ALT_W           = 24;
   localparam int AZ_W            = 25;
   localparam int CODE_W          = 2;

   // Internal datapath widths
   localparam int ANG_W      = 40;  // Q28 degrees
   localparam int ROT_W      = 34;  // Q30 sines and cosines
   localparam int VEC_W      = 36;  // vectoring x/y
   localparam int S_W        = 32;  // saturated sinAlt
   localparam int SQ_W       = 62;  // square root operand
   localparam int SQRT_STEPS = 31;
   localparam int ROOT_W     = 31;
   localparam int SHC_W      = 6;
   localparam int NORM_TOP   = 29;  // normalize until bit 29 is reached

   localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(64'd90 << INT_FRAC);
   localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(64'd180 << INT_FRAC);
   localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(64'd360 << INT_FRAC);
   localparam logic signed [ROT_W-1:0] CORDIC_GAIN = ROT_W'(64'd652032874);
   localparam logic signed [S_W-1:0]   ONE_Q30     = S_W'(64'd1 << 30);
   localparam logic [ROOT_W-1:0]       ZENITH_EPS  = ROOT_W'(64'd10738);

   // Output-format angles
   localparam logic signed [ANG_W-1:0] OUT_HALF = ANG_W'(64'd1 << (UP_SH - 1));
   localparam logic signed [ANG_W-1:0] OUT_90   = ANG_W'(64'd90 << ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] OUT_180  = ANG_W'(64'd180 << ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] OUT_270  = ANG_W'(64'd270 << ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] OUT_360  = ANG_W'(64'd360 << ANGLE_FRAC_BITS);

   typedef enum logic [CODE_W-1:0] {
      SC_NORMAL  = 2'd0,
      SC_ZENITH  = 2'd1,
      SC_NULL_AZ = 2'd2
   } special_type;

   // Values carried alongside the square root pipeline
   typedef struct packed {
      logic signed [S_W-1:0]   s_alt;
      logic signed [ROT_W:0]   a_cos;
      logic signed [ROT_W-1:0] a_sin;
      logic                    sh_neg;
      logic                    dec_pos;
   } side_type;

   // Flags carried through the vectoring pipeline
   typedef struct packed {
      logic zenith;
      logic null_az;
      logic sh_neg;
      logic dec_pos;
   } flag_type;

   // Q30 product, floor-shifted back to Q30
   function automatic logic signed [ROT_W-1:0] mul_q30(input logic signed [ROT_W-1:0] a,
                                                      input logic signed [ROT_W-1:0] b);
      logic signed [2*ROT_W-1:0] p;
      p = a * b;
      return ROT_W'(p >>> 30);
   endfunction

   // atan(2^-i) in Q28 degrees, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_q28(input int unsigned idx);
      logic [63:0] v;
      case (idx)
         0:  v = 64'd12079595520;
         1:  v = 64'd7131001626;
         2:  v = 64'd3767825416;
         3:  v = 64'd1912607013;
         4:  v = 64'd960014948;
         5:  v = 64'd480475470;
         6:  v = 64'd240296364;
         7:  v = 64'd120155517;
         8:  v = 64'd60078674;
         9:  v = 64'd30039451;
         10: v = 64'd15019740;
         11: v = 64'd7509872;
         12: v = 64'd3754936;
         13: v = 64'd1877468;
         14: v = 64'd938734;
         15: v = 64'd469367;
         16: v = 64'd234684;
         17: v = 64'd117342;
         18: v = 64'd58671;
         19: v = 64'd29335;
         20: v = 64'd14668;
         21: v = 64'd7334;
         22: v = 64'd3667;
         23: v = 64'd1833;
         24: v = 64'd917;
         25: v = 64'd458;
         26: v = 64'd229;
         27: v = 64'd115;
         28: v = 64'd57;
         29: v = 64'd29;
         30: v = 64'd14;
         31: v = 64'd7;
         default: v = 64'd0;
      endcase
      return ANG_W'(v);
   endfunction

endpackage

>>> rtl/equatorial_to_alt_az.sv
// Equatorial (latitude, hour angle, declination) to altitude/azimuth converter.
//
// Input channel req_*: one transaction carries latitude and declination in
// degrees and hour angle in hours, signed with ANGLE_FRAC_BITS fraction bits.
// Result channel rsp_*: altitude, azimuth (0..360) and a special_case code
// (normal, near-zenith rule, or both azimuth terms zero).
// Both channels use valid/ready; a transaction moves when both are high.
//
// Throughput: one transaction per cycle while rsp_ready does not stall the
// pipeline. The pipeline is the chain of three parallel rotation CORDICs
// (CORDIC_STAGES), two multiply stages, the 31-step square root and two
// parallel vectoring CORDICs (CORDIC_STAGES), plus the input, fold-undo,
// sinAlt sum, normalization, product and output registers.
//
// Reset clears every valid bit; the pipeline comes up empty and req_ready
// is high. When the receiver holds rsp_ready low with a result pending, the
// whole pipeline holds in place and req_ready drops; nothing is lost or
// repeated. No state is kept between transactions.
module equatorial_to_alt_az (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [eqaa_pkg::LAT_W-1:0]   req_latitude,
   input  logic signed [eqaa_pkg::HA_W-1:0]    req_hour_angle,
   input  logic signed [eqaa_pkg::DEC_W-1:0]   req_declination,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [eqaa_pkg::ALT_W-1:0]   rsp_altitude,
   output logic        [eqaa_pkg::AZ_W-1:0]    rsp_azimuth,
   output logic        [eqaa_pkg::CODE_W-1:0]  rsp_special_case
);
   import eqaa_pkg::*;

   localparam int N = CORDIC_STAGES;

   logic adv;
   logic rsp_valid_ff;
   logic signed [ALT_W-1:0] rsp_altitude_ff;
   logic [AZ_W-1:0]         rsp_azimuth_ff;
   special_type             rsp_code_ff;

   // Whole pipeline advances unless a result is stuck at the output
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------
   // Input scaling and quadrant fold for lat / ha / dec
   // ---------------------------------------------------------------
   logic signed [ANG_W-1:0] ang_raw [3];
   logic signed [ANG_W-1:0] ha_ext;
   logic signed [ANG_W-1:0] fold_in [3];
   logic [2:0]              neg_in;

   always_comb begin
      ha_ext     = ANG_W'(req_hour_angle);
      ang_raw[0] = ANG_W'(req_latitude) <<< UP_SH;
      ang_raw[1] = ((ha_ext <<< 4) - ha_ext) <<< UP_SH;
      ang_raw[2] = ANG_W'(req_declination) <<< UP_SH;
      for (int l = 0; l < 3; l++) begin
         fold_in[l] = ang_raw[l];
         neg_in[l]  = 1'b0;
         if (fold_in[l] > DEG180) begin
            fold_in[l] = fold_in[l] - DEG360;
         end else if (fold_in[l] < -DEG180) begin
            fold_in[l] = fold_in[l] + DEG360;
         end
         if (fold_in[l] > DEG90) begin
            fold_in[l] = fold_in[l] - DEG180;
            neg_in[l]  = 1'b1;
         end else if (fold_in[l] < -DEG90) begin
            fold_in[l] = fold_in[l] + DEG180;
            neg_in[l]  = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Rotation CORDIC: three lanes (0 lat, 1 ha, 2 dec)
   // ---------------------------------------------------------------
   logic                    rv_ff  [0:N];
   logic signed [ROT_W-1:0] rx_ff  [0:N][3];
   logic signed [ROT_W-1:0] ry_ff  [0:N][3];
   logic signed [ANG_W-1:0] rz_ff  [0:N][3];
   logic [2:0]              rneg_ff[0:N];
   logic                    rdp_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (adv) begin
         rv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            rx_ff[0][l] <= CORDIC_GAIN;
            ry_ff[0][l] <= '0;
            rz_ff[0][l] <= fold_in[l];
         end
         rneg_ff[0] <= neg_in;
         rdp_ff[0]  <= (req_declination > 0);
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_rot
      logic signed [ROT_W-1:0] x_in [3];
      logic signed [ROT_W-1:0] y_in [3];
      logic signed [ANG_W-1:0] z_in [3];

      // One micro-rotation toward zero residual angle
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (rz_ff[k][l] >= 0) begin
               x_in[l] = rx_ff[k][l] - (ry_ff[k][l] >>> k);
               y_in[l] = ry_ff[k][l] + (rx_ff[k][l] >>> k);
               z_in[l] = rz_ff[k][l] - atan_q28(k);
            end else begin
               x_in[l] = rx_ff[k][l] + (ry_ff[k][l] >>> k);
               y_in[l] = ry_ff[k][l] - (rx_ff[k][l] >>> k);
               z_in[l] = rz_ff[k][l] + atan_q28(k);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            rv_ff[k+1] <= rv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               rx_ff[k+1][l] <= x_in[l];
               ry_ff[k+1][l] <= y_in[l];
               rz_ff[k+1][l] <= z_in[l];
            end
            rneg_ff[k+1] <= rneg_ff[k];
            rdp_ff[k+1]  <= rdp_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Undo the quadrant fold
   // ---------------------------------------------------------------
   logic                    tv_ff;
   logic signed [ROT_W-1:0] cos_ff [3];
   logic signed [ROT_W-1:0] sin_ff [3];
   logic                    tdp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (adv) begin
         tv_ff <= rv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            cos_ff[l] <= rneg_ff[N][l] ? -rx_ff[N][l] : rx_ff[N][l];
            sin_ff[l] <= rneg_ff[N][l] ? -ry_ff[N][l] : ry_ff[N][l];
         end
         tdp_ff <= rdp_ff[N];
      end
   end

   // ---------------------------------------------------------------
   // First products: ch*cd, sd*sl, cd*sh, cl*sd
   // ---------------------------------------------------------------
   logic                    m1v_ff;
   logic signed [ROT_W-1:0] m1_p1_ff, m1_p2_ff, m1_as_ff, m1_p3_ff, m1_cl_ff, m1_sl_ff;
   logic                    m1_shneg_ff, m1_dp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1v_ff <= 1'b0;
      end else if (adv) begin
         m1v_ff <= tv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_p1_ff    <= mul_q30(cos_ff[1], cos_ff[2]);
         m1_p2_ff    <= mul_q30(sin_ff[2], sin_ff[0]);
         m1_as_ff    <= mul_q30(cos_ff[2], sin_ff[1]);
         m1_p3_ff    <= mul_q30(cos_ff[0], sin_ff[2]);
         m1_cl_ff    <= cos_ff[0];
         m1_sl_ff    <= sin_ff[0];
         m1_shneg_ff <= sin_ff[1][ROT_W-1];
         m1_dp_ff    <= tdp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Second products: (ch*cd)*cl and sl*(cd*ch)
   // ---------------------------------------------------------------
   logic                    m2v_ff;
   logic signed [ROT_W-1:0] m2_q1_ff, m2_q2_ff, m2_p2_ff, m2_p3_ff, m2_as_ff;
   logic                    m2_shneg_ff, m2_dp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2v_ff <= 1'b0;
      end else if (adv) begin
         m2v_ff <= m1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_q1_ff    <= mul_q30(m1_p1_ff, m1_cl_ff);
         m2_q2_ff    <= mul_q30(m1_sl_ff, m1_p1_ff);
         m2_p2_ff    <= m1_p2_ff;
         m2_p3_ff    <= m1_p3_ff;
         m2_as_ff    <= m1_as_ff;
         m2_shneg_ff <= m1_shneg_ff;
         m2_dp_ff    <= m1_dp_ff;
      end
   end

   // ---------------------------------------------------------------
   // sinAlt with saturation, and Ac
   // ---------------------------------------------------------------
   logic                    m3v_ff;
   logic signed [ROT_W:0]   s_sum;
   logic signed [S_W-1:0]   s_in;
   logic signed [S_W-1:0]   m3_s_ff;
   logic signed [ROT_W:0]   m3_ac_ff;
   logic signed [ROT_W-1:0] m3_as_ff;
   logic                    m3_shneg_ff, m3_dp_ff;

   always_comb begin
      s_sum = (ROT_W+1)'(m2_q1_ff) + (ROT_W+1)'(m2_p2_ff);
      if (s_sum > (ROT_W+1)'(ONE_Q30)) begin
         s_in = ONE_Q30;
      end else if (s_sum < -(ROT_W+1)'(ONE_Q30)) begin
         s_in = -ONE_Q30;
      end else begin
         s_in = S_W'(s_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3v_ff <= 1'b0;
      end else if (adv) begin
         m3v_ff <= m2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_s_ff     <= s_in;
         m3_ac_ff    <= (ROT_W+1)'(m2_q2_ff) - (ROT_W+1)'(m2_p3_ff);
         m3_as_ff    <= m2_as_ff;
         m3_shneg_ff <= m2_shneg_ff;
         m3_dp_ff    <= m2_dp_ff;
      end
   end

   // ---------------------------------------------------------------
   // sinAlt squared
   // ---------------------------------------------------------------
   logic                    m4v_ff;
   logic signed [2*S_W-1:0] sq_prod;
   logic [SQ_W-1:0]         m4_sq_ff;
   side_type                m4_side_ff;

   assign sq_prod = m3_s_ff * m3_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m4v_ff <= 1'b0;
      end else if (adv) begin
         m4v_ff <= m3v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m4_sq_ff           <= SQ_W'(sq_prod);
         m4_side_ff.s_alt   <= m3_s_ff;
         m4_side_ff.a_cos   <= m3_ac_ff;
         m4_side_ff.a_sin   <= m3_as_ff;
         m4_side_ff.sh_neg  <= m3_shneg_ff;
         m4_side_ff.dec_pos <= m3_dp_ff;
      end
   end

   // ---------------------------------------------------------------
   // zSin = floor(sqrt(2^60 - sinAlt^2)), one result bit per stage
   // ---------------------------------------------------------------
   localparam int SQ_TOP = 2 * (SQRT_STEPS - 1);

   logic            qv_ff   [0:SQRT_STEPS];
   logic [SQ_W-1:0] rem_ff  [0:SQRT_STEPS];
   logic [SQ_W-1:0] root_ff [0:SQRT_STEPS];
   side_type        qside_ff[0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff[0] <= 1'b0;
      end else if (adv) begin
         qv_ff[0] <= m4v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]   <= (SQ_W'(64'd1) << SQ_TOP) - m4_sq_ff;
         root_ff[0]  <= '0;
         qside_ff[0] <= m4_side_ff;
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(64'd1) << (SQ_TOP - 2 * j);
      logic [SQ_W-1:0] trial;
      logic [SQ_W-1:0] rem_in;
      logic [SQ_W-1:0] root_in;

      always_comb begin
         trial = root_ff[j] + BIT;
         if (rem_ff[j] >= trial) begin
            rem_in  = rem_ff[j] - trial;
            root_in = (root_ff[j] >> 1) + BIT;
         end else begin
            rem_in  = rem_ff[j];
            root_in = root_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            qv_ff[j+1] <= qv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1]   <= rem_in;
            root_ff[j+1]  <= root_in;
            qside_ff[j+1] <= qside_ff[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // Vector setup and shift count (lane 0 altitude, lane 1 azimuth)
   // ---------------------------------------------------------------
   side_type                sd;
   logic [ROOT_W-1:0]       zsin;
   logic signed [VEC_W-1:0] sx_in [2];
   logic signed [VEC_W-1:0] sy_in [2];
   logic [VEC_W-1:0]        mag   [2];
   logic [SHC_W-1:0]        lead  [2];
   logic [SHC_W-1:0]        shc_in[2];
   logic signed [ANG_W-1:0] off_in;

   assign sd   = qside_ff[SQRT_STEPS];
   assign zsin = root_ff[SQRT_STEPS][ROOT_W-1:0];

   always_comb begin
      sx_in[0] = VEC_W'(zsin);
      sy_in[0] = VEC_W'(sd.s_alt);
      sx_in[1] = VEC_W'(sd.a_cos);
      sy_in[1] = VEC_W'(sd.a_sin);
      off_in   = '0;
      // Left half-plane: flip into the right half and add a half turn
      if (sd.a_cos < 0) begin
         sx_in[1] = -VEC_W'(sd.a_cos);
         sy_in[1] = -VEC_W'(sd.a_sin);
         off_in   = (sd.a_sin >= 0) ? DEG180 : -DEG180;
      end
      for (int l = 0; l < 2; l++) begin
         mag[l]  = sx_in[l] | ((sy_in[l] < 0) ? -sy_in[l] : sy_in[l]);
         lead[l] = '0;
         for (int i = 0; i < VEC_W; i++) begin
            if (mag[l][i]) begin
               lead[l] = SHC_W'(i);
            end
         end
         shc_in[l] = (lead[l] >= SHC_W'(NORM_TOP)) ? '0 : SHC_W'(NORM_TOP) - lead[l];
      end
   end

   logic                    nv_ff;
   logic signed [VEC_W-1:0] nx_ff  [2];
   logic signed [VEC_W-1:0] ny_ff  [2];
   logic [SHC_W-1:0]        nshc_ff[2];
   logic signed [ANG_W-1:0] noff_ff;
   flag_type                nflag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else if (adv) begin
         nv_ff <= qv_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            nx_ff[l]   <= sx_in[l];
            ny_ff[l]   <= sy_in[l];
            nshc_ff[l] <= shc_in[l];
         end
         noff_ff          <= off_in;
         nflag_ff.zenith  <= (zsin < ZENITH_EPS);
         nflag_ff.null_az <= (sd.a_cos == '0) && (sd.a_sin == '0);
         nflag_ff.sh_neg  <= sd.sh_neg;
         nflag_ff.dec_pos <= sd.dec_pos;
      end
   end

   // ---------------------------------------------------------------
   // Vectoring CORDIC: normalize, then drive y toward zero
   // ---------------------------------------------------------------
   logic                    vv_ff  [0:N];
   logic signed [VEC_W-1:0] vx_ff  [0:N][2];
   logic signed [VEC_W-1:0] vy_ff  [0:N][2];
   logic signed [ANG_W-1:0] vz_ff  [0:N][2];
   flag_type                vflag_ff[0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff[0] <= 1'b0;
      end else if (adv) begin
         vv_ff[0] <= nv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            vx_ff[0][l] <= nx_ff[l] <<< nshc_ff[l];
            vy_ff[0][l] <= ny_ff[l] <<< nshc_ff[l];
         end
         vz_ff[0][0] <= '0;
         vz_ff[0][1] <= noff_ff;
         vflag_ff[0] <= nflag_ff;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_vec
      logic signed [VEC_W-1:0] x_in [2];
      logic signed [VEC_W-1:0] y_in [2];
      logic signed [ANG_W-1:0] z_in [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (vy_ff[k][l] > 0) begin
               x_in[l] = vx_ff[k][l] + (vy_ff[k][l] >>> k);
               y_in[l] = vy_ff[k][l] - (vx_ff[k][l] >>> k);
               z_in[l] = vz_ff[k][l] + atan_q28(k);
            end else begin
               x_in[l] = vx_ff[k][l] - (vy_ff[k][l] >>> k);
               y_in[l] = vy_ff[k][l] + (vx_ff[k][l] >>> k);
               z_in[l] = vz_ff[k][l] - atan_q28(k);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vv_ff[k+1] <= vv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 2; l++) begin
               vx_ff[k+1][l] <= x_in[l];
               vy_ff[k+1][l] <= y_in[l];
               vz_ff[k+1][l] <= z_in[l];
            end
            vflag_ff[k+1] <= vflag_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Rounding, special cases and saturation into the output register
   // ---------------------------------------------------------------
   flag_type                fl;
   logic signed [ANG_W-1:0] alt_r, az_r;
   logic signed [ANG_W-1:0] alt_in, az_in;
   special_type             code_in;

   assign fl = vflag_ff[N];

   always_comb begin
      alt_r   = (vz_ff[N][0] + OUT_HALF) >>> UP_SH;
      az_r    = (vz_ff[N][1] + DEG180 + OUT_HALF) >>> UP_SH;
      alt_in  = alt_r;
      az_in   = az_r;
      code_in = SC_NORMAL;
      if (fl.zenith) begin
         alt_in  = OUT_90;
         az_in   = fl.sh_neg ? OUT_90 : OUT_270;
         code_in = SC_ZENITH;
      end else if (fl.null_az) begin
         az_in   = fl.dec_pos ? OUT_180 : '0;
         code_in = SC_NULL_AZ;
      end
      if (alt_in > OUT_90) begin
         alt_in = OUT_90;
      end else if (alt_in < -OUT_90) begin
         alt_in = -OUT_90;
      end
      if (az_in > OUT_360) begin
         az_in = OUT_360;
      end else if (az_in < 0) begin
         az_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_altitude_ff <= ALT_W'(alt_in);
         rsp_azimuth_ff  <= AZ_W'(az_in);
         rsp_code_ff     <= code_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_altitude     = rsp_altitude_ff;
   assign rsp_azimuth      = rsp_azimuth_ff;
   assign rsp_special_case = rsp_code_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_zenith_alt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_code_ff == SC_ZENITH |->
         rsp_altitude_ff == ALT_W'(OUT_90) &&
         (rsp_azimuth_ff == AZ_W'(OUT_90) || rsp_azimuth_ff == AZ_W'(OUT_270)))
      else $error("zenith rule gave wrong altitude or azimuth");

   a_null_az: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_code_ff == SC_NULL_AZ |->
         rsp_azimuth_ff == '0 || rsp_azimuth_ff == AZ_W'(OUT_180))
      else $error("null azimuth rule gave wrong azimuth");

   a_az_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_azimuth_ff <= AZ_W'(OUT_360))
      else $error("azimuth beyond 360 degrees");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vv_ff[N] == $past(vv_ff[N]) && qv_ff[0] == $past(qv_ff[0]) &&
               rv_ff[0] == $past(rv_ff[0]))
      else $error("pipeline occupancy changed during a stall");

endmodule
